@@ hdl/mhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and codes of the binary min-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

	localparam int DEF_CAPACITY = 64;
	localparam int KEY_W        = 32;
	localparam int SLOT_W       = 6;
	localparam int LIMIT_W      = 7;
	localparam int CNT_OUT_W    = 7;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

	localparam logic [1:0] OP_INSERT   = 2'd0;
	localparam logic [1:0] OP_DEL_KEY  = 2'd1;
	localparam logic [1:0] OP_DEL_SLOT = 2'd2;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_BAD_INDEX = 2'd3;

	typedef struct packed {
		logic [1:0]              opcode;
		logic signed [KEY_W-1:0] key_value;
		logic [SLOT_W-1:0]       slot_index;
	} cmd_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [KEY_W-1:0] removed_key;
		logic signed [KEY_W-1:0] min_key;
		logic [CNT_OUT_W-1:0]    key_count;
	} rsp_t;

endpackage

`default_nettype wire

@@ hdl/min_heap_priority_queue_core.sv @@
// ----------------------------------------------------------------------------
// min_heap_priority_queue_core
// Binary min-heap of signed 32-bit keys held in one synchronous memory.
// ----------------------------------------------------------------------------
// One command in flight at a time, one response beat per command. The keys sit
// in a simple dual-port memory (one write, one registered read per cycle), and
// that single read port sets the timing: an insert climbs the heap one level
// at a time; a delete at an index moves the last key into the hole, sifts it
// down and then up; a delete by value first scans the heap one entry per cycle
// and then runs the same removal. A new command is taken while the previous
// response still waits in the output register.
// No clearing pass after reset: only entries below the count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module min_heap_priority_queue_core
	import mhpq_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_ready,
	input  wire cmd_t               cmd,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output rsp_t                    rsp,
	input  wire logic               cfg_wr_en,
	input  wire logic [LIMIT_W-1:0] cfg_wr_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam int SW = (CW > SLOT_W) ? CW : SLOT_W;
	localparam int IW = AW + 2;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_SCAN  = 11'b000_0000_0010,
		S_RM_G  = 11'b000_0000_0100,
		S_RM_A  = 11'b000_0000_1000,
		S_RM_B  = 11'b000_0001_0000,
		S_DN_L  = 11'b000_0010_0000,
		S_DN_R  = 11'b000_0100_0000,
		S_DN_C  = 11'b000_1000_0000,
		S_UP_RD = 11'b001_0000_0000,
		S_UP_C  = 11'b010_0000_0000,
		S_DONE  = 11'b100_0000_0000
	} state_t;

	logic signed [KEY_W-1:0] heap_mem [CAPACITY];

	state_t                  state_q, state_d;
	logic [CW-1:0]           cnt_q;
	logic [LIMIT_W-1:0]      cap_q;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;
	logic [CW-1:0]           scan_q;
	logic                    rd_vld_s1;
	logic [AW-1:0]           idx_s1;
	logic signed [KEY_W-1:0] rdata_s1;
	logic signed [KEY_W-1:0] cur_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [KEY_W-1:0] gone_q;
	logic signed [KEY_W-1:0] root_q;
	logic signed [KEY_W-1:0] lkey_q;
	logic                    has_r_q;
	logic [AW-1:0]           pos_q;
	logic [1:0]              status_q;

	logic                    cmd_acc;
	logic                    room;
	logic                    slot_ok;
	logic                    scan_hit;
	logic                    scan_end;
	logic                    rsp_load;
	logic [AW-1:0]           last_idx;
	logic [AW-1:0]           par_idx;
	logic [IW-1:0]           l_w, r_w, cnt_iw;
	logic                    pick_right;
	logic signed [KEY_W-1:0] pick_key;
	logic [AW-1:0]           pick_idx;

	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic signed [KEY_W-1:0] wr_data;
	logic [AW-1:0]           rd_addr;

	assign cmd_ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd_valid && cmd_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign room     = (LW'(cnt_q) < LW'(cap_q)) && (cnt_q < CW'(CAPACITY));
	assign slot_ok  = SW'(cmd.slot_index) < SW'(cnt_q);
	assign last_idx = AW'(cnt_q - 1'b1);
	assign par_idx  = AW'((pos_q - 1'b1) >> 1);
	assign l_w      = IW'({pos_q, 1'b1});
	assign r_w      = l_w + IW'(1);
	assign cnt_iw   = IW'(cnt_q);
	assign scan_hit = rd_vld_s1 && (rdata_s1 == key_q);
	assign scan_end = (scan_q >= cnt_q) && !rd_vld_s1;
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	// ties go to the right child
	assign pick_right = has_r_q && !(lkey_q < rdata_s1);
	assign pick_key   = pick_right ? rdata_s1 : lkey_q;
	assign pick_idx   = pick_right ? AW'(r_w) : AW'(l_w);

	// sifting keeps the moving key in cur_q and leaves a hole at pos_q
	always_comb begin
		state_d = state_q;
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = cur_q;
		rd_addr = pos_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					case (cmd.opcode)
						OP_INSERT:   state_d = room ? S_UP_RD : S_DONE;
						OP_DEL_KEY:  state_d = S_SCAN;
						OP_DEL_SLOT: state_d = slot_ok ? S_RM_G : S_DONE;
						default:     state_d = S_DONE;
					endcase
				end
			end
			S_SCAN: begin
				rd_addr = AW'(scan_q);
				if (scan_hit) begin
					state_d = S_RM_G;
				end else if (scan_end) begin
					state_d = S_DONE;
				end
			end
			S_RM_G: begin
				state_d = S_RM_A;
			end
			S_RM_A: begin
				rd_addr = last_idx;
				state_d = S_RM_B;
			end
			S_RM_B: begin
				state_d = (pos_q == last_idx) ? S_DONE : S_DN_L;
			end
			S_DN_L: begin
				if (l_w >= cnt_iw) begin
					state_d = S_UP_RD;
				end else begin
					rd_addr = AW'(l_w);
					state_d = S_DN_R;
				end
			end
			S_DN_R: begin
				rd_addr = AW'(r_w);
				state_d = S_DN_C;
			end
			S_DN_C: begin
				if (pick_key < cur_q) begin
					wr_en   = 1'b1;
					wr_data = pick_key;
					state_d = S_DN_L;
				end else begin
					state_d = S_UP_RD;
				end
			end
			S_UP_RD: begin
				if (pos_q == '0) begin
					wr_en   = 1'b1;
					state_d = S_DONE;
				end else begin
					rd_addr = par_idx;
					state_d = S_UP_C;
				end
			end
			S_UP_C: begin
				wr_en = 1'b1;
				if (cur_q < rdata_s1) begin
					wr_data = rdata_s1;
					state_d = S_UP_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			heap_mem[wr_addr] <= wr_data;
		end
		rdata_s1 <= heap_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			cap_q       <= LIMIT_RESET;
			rsp_valid_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (cmd_acc && cmd.opcode == OP_INSERT && room) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (state_q == S_RM_B) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (state_q == S_SCAN) begin
				rd_vld_s1 <= !scan_hit && (scan_q < cnt_q);
			end else begin
				rd_vld_s1 <= 1'b0;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_addr == '0) begin
			root_q <= wr_data;
		end
		case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					key_q    <= cmd.key_value;
					cur_q    <= cmd.key_value;
					gone_q   <= '0;
					scan_q   <= '0;
					status_q <= ST_DONE;
					case (cmd.opcode)
						OP_INSERT: begin
							pos_q <= AW'(cnt_q);
							if (!room) begin
								status_q <= ST_FULL;
							end
						end
						OP_DEL_SLOT: begin
							pos_q <= AW'(cmd.slot_index);
							if (!slot_ok) begin
								status_q <= ST_BAD_INDEX;
							end
						end
						default: pos_q <= '0;
					endcase
				end
			end
			S_SCAN: begin
				idx_s1 <= AW'(scan_q);
				if (scan_q < cnt_q) begin
					scan_q <= scan_q + 1'b1;
				end
				if (scan_hit) begin
					pos_q <= idx_s1;
				end else if (scan_end) begin
					status_q <= ST_NOT_FOUND;
				end
			end
			S_RM_A: gone_q <= rdata_s1;
			S_RM_B: cur_q  <= rdata_s1;
			S_DN_R: begin
				lkey_q  <= rdata_s1;
				has_r_q <= r_w < cnt_iw;
			end
			S_DN_C: begin
				if (pick_key < cur_q) begin
					pos_q <= pick_idx;
				end
			end
			S_UP_C: begin
				if (cur_q < rdata_s1) begin
					pos_q <= par_idx;
				end
			end
			default: ;
		endcase
		if (rsp_load) begin
			rsp_q.status      <= status_q;
			rsp_q.removed_key <= gone_q;
			rsp_q.min_key     <= (cnt_q != '0) ? root_q : '0;
			rsp_q.key_count   <= CNT_OUT_W'(cnt_q);
		end
	end

endmodule

`default_nettype wire

@@ hdl/mhpq_checker.sv @@
// ----------------------------------------------------------------------------
// mhpq_checker
// Port-level checks on the min-heap priority queue, bound to the core module.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_checker
	import mhpq_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire logic cmd_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp
);

	// empty heap reports a zero minimum
	a_empty_min: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.key_count == '0 |-> rsp.min_key == '0)
		else $error("min_key not zero on empty heap");

	// nothing removed unless the beat reports success
	a_fail_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_NOT_FOUND ||
		rsp.status == ST_BAD_INDEX) |-> rsp.removed_key == '0)
		else $error("removed_key set on failed command");

	// a command is not taken in the cycle after one was taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("second command taken while one in flight");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response beat changed");

endmodule

bind min_heap_priority_queue_core mhpq_checker u_mhpq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire

@@ dv/min_heap_priority_queue_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue_core_tb
// Self-checking regression for the binary min-heap priority queue core.
// ----------------------------------------------------------------------------
// A clocked driver feeds command beats from a queue that the stimulus block
// fills: a short directed run over full, empty, not-found, bad-index, spare
// opcode and tie cases, then random phases under several capacity limits.
// Each accepted command is run through a local heap model and the response
// it should give is queued; a clocked monitor checks every response beat
// field by field. Both sides idle in random bursts, except near the end.
// The limit register is only written once all responses have come back.
// ----------------------------------------------------------------------------
`default_nettype none

module min_heap_priority_queue_core_tb;
	import mhpq_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 20;
	localparam int PHASE_ITEMS    = 175;

	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef logic signed [KEY_W-1:0] key_t;

	localparam key_t KEY_MAX = 32'sh7fffffff;
	localparam key_t KEY_MIN = 32'sh80000000;

	typedef enum bit {STIM_CMD, STIM_LIMIT} stim_kind_t;

	typedef struct {
		stim_kind_t         kind;
		cmd_t               cmd;
		logic [LIMIT_W-1:0] limit;
		bit                 calm;
	} stim_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cmd_valid   = 1'b0;
	cmd_t               cmd         = '0;
	logic               rsp_ready   = 1'b0;
	logic               cfg_wr_en   = 1'b0;
	logic [LIMIT_W-1:0] cfg_wr_data = '0;
	logic               cmd_ready;
	logic               rsp_valid;
	rsp_t               rsp;

	stim_t pending_q[$];
	rsp_t  expected_rsp_q[$];

	key_t               heap_keys [DEF_CAPACITY];
	int unsigned        heap_size  = 0;
	logic [LIMIT_W-1:0] heap_limit = LIMIT_RESET;

	int error_count = 0;
	int idle_cycles = 0;
	int gap_left    = 0;
	int stall_left  = 0;
	int settle_cnt  = 0;
	bit calm_mode   = 1'b0;
	bit stim_calm   = 1'b0;

	always #5 clk = ~clk;

	min_heap_priority_queue_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// ---- heap model ----

	function automatic void heap_swap(int unsigned a, int unsigned b);
		key_t t;
		t            = heap_keys[a];
		heap_keys[a] = heap_keys[b];
		heap_keys[b] = t;
	endfunction

	function automatic void heap_sift_up(int unsigned start);
		int unsigned i;
		i = start;
		while (i > 0 && heap_keys[i] < heap_keys[(i - 1) / 2]) begin
			heap_swap(i, (i - 1) / 2);
			i = (i - 1) / 2;
		end
	endfunction

	// last key fills the hole, sinks (right child wins ties), then may rise
	function automatic key_t heap_remove(int unsigned idx);
		key_t        gone;
		int unsigned i;
		int unsigned l;
		int unsigned r;
		int unsigned pick;
		bit          moving;
		gone = heap_keys[idx];
		heap_size--;
		heap_keys[idx] = heap_keys[heap_size];
		if (idx < heap_size) begin
			i      = idx;
			moving = 1'b1;
			while (moving) begin
				l = 2 * i + 1;
				r = l + 1;
				if (l >= heap_size) begin
					moving = 1'b0;
				end else begin
					pick = (r < heap_size && !(heap_keys[l] < heap_keys[r])) ? r : l;
					if (heap_keys[pick] < heap_keys[i]) begin
						heap_swap(i, pick);
						i = pick;
					end else begin
						moving = 1'b0;
					end
				end
			end
			heap_sift_up(i);
		end
		return gone;
	endfunction

	function automatic rsp_t heap_apply(cmd_t c);
		rsp_t        r;
		int unsigned lim;
		int unsigned i;
		r        = '0;
		r.status = ST_DONE;
		lim      = (heap_limit < DEF_CAPACITY) ? heap_limit : DEF_CAPACITY;
		case (c.opcode)
			OP_INSERT: begin
				if (heap_size < lim) begin
					heap_keys[heap_size] = c.key_value;
					heap_sift_up(heap_size);
					heap_size++;
				end else begin
					r.status = ST_FULL;
				end
			end
			OP_DEL_KEY: begin
				i = 0;
				while (i < heap_size && heap_keys[i] != c.key_value)
					i++;
				if (i < heap_size)
					r.removed_key = heap_remove(i);
				else
					r.status = ST_NOT_FOUND;
			end
			OP_DEL_SLOT: begin
				if (c.slot_index < heap_size)
					r.removed_key = heap_remove(c.slot_index);
				else
					r.status = ST_BAD_INDEX;
			end
			default: begin
			end
		endcase
		r.min_key   = (heap_size > 0) ? heap_keys[0] : '0;
		r.key_count = CNT_OUT_W'(heap_size);
		return r;
	endfunction

	// ---- stimulus queue ----

	task automatic queue_cmd(logic [1:0] op, key_t key, logic [SLOT_W-1:0] slot);
		stim_t s;
		s.kind             = STIM_CMD;
		s.cmd.opcode       = op;
		s.cmd.key_value    = key;
		s.cmd.slot_index   = slot;
		s.limit            = '0;
		s.calm             = stim_calm;
		pending_q.push_back(s);
	endtask

	task automatic queue_limit(logic [LIMIT_W-1:0] lim);
		stim_t s;
		s.kind  = STIM_LIMIT;
		s.cmd   = '0;
		s.limit = lim;
		s.calm  = stim_calm;
		pending_q.push_back(s);
	endtask

	// ---- driver ----

	always @(posedge clk or negedge arst_n) begin : drive_cmds
		stim_t next_stim;
		bit    fire_cfg;
		if (!arst_n) begin
			cmd_valid  <= 1'b0;
			cfg_wr_en  <= 1'b0;
			gap_left   = 0;
			settle_cnt = 0;
		end else begin
			fire_cfg = 1'b0;
			if (cmd_valid && cmd_ready)
				expected_rsp_q.push_back(heap_apply(cmd));
			if (!cmd_valid || cmd_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd_valid <= 1'b0;
				end else if (pending_q.size() == 0) begin
					cmd_valid <= 1'b0;
				end else if (pending_q[0].kind == STIM_CMD) begin
					next_stim = pending_q.pop_front();
					calm_mode = next_stim.calm;
					cmd       <= next_stim.cmd;
					cmd_valid <= 1'b1;
					if (!next_stim.calm && $urandom_range(0, 5) == 0)
						gap_left = $urandom_range(1, 18);
				end else begin
					// limit change: hold off until every response is back
					cmd_valid  <= 1'b0;
					settle_cnt = (expected_rsp_q.size() == 0) ? settle_cnt + 1 : 0;
					if (settle_cnt >= SETTLE_CYCLES) begin
						next_stim   = pending_q.pop_front();
						heap_limit  = next_stim.limit;
						cfg_wr_data <= next_stim.limit;
						fire_cfg    = 1'b1;
						settle_cnt  = 0;
					end
				end
			end
			cfg_wr_en <= fire_cfg;
		end
	end

	// ---- monitor ----

	always @(posedge clk or negedge arst_n) begin : check_rsps
		rsp_t want;
		if (!arst_n) begin
			rsp_ready  <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp_q.size() == 0) begin
					error_count++;
					$error("response beat with none expected: status %0d", rsp.status);
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.status !== want.status) begin
						error_count++;
						$error("status: expected %0d, actual %0d", want.status, rsp.status);
					end
					if (rsp.removed_key !== want.removed_key) begin
						error_count++;
						$error("removed_key: expected %0d, actual %0d",
							want.removed_key, rsp.removed_key);
					end
					if (rsp.min_key !== want.min_key) begin
						error_count++;
						$error("min_key: expected %0d, actual %0d", want.min_key, rsp.min_key);
					end
					if (rsp.key_count !== want.key_count) begin
						error_count++;
						$error("key_count: expected %0d, actual %0d",
							want.key_count, rsp.key_count);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if (!calm_mode && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 17);
				rsp_ready  <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// ---- watchdog ----

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) || cfg_wr_en) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("min_heap_priority_queue_core regression: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// ---- stimulus and end of run ----

	initial begin : run_regression
		key_t               key_pool [16];
		int                 roll;
		int                 ins_pct;
		logic [1:0]         op;
		key_t               key;
		logic [SLOT_W-1:0]  slot;
		logic [LIMIT_W-1:0] lim;

		// small heap: extremes, full, not found, spare opcode, bad index
		queue_limit(7'd4);
		queue_cmd(OP_INSERT, KEY_MAX, 6'd0);
		queue_cmd(OP_INSERT, KEY_MIN, 6'd0);
		queue_cmd(OP_INSERT, 32'sd0, 6'd0);
		queue_cmd(OP_INSERT, -32'sd1, 6'd0);
		queue_cmd(OP_INSERT, 32'sd7, 6'd0);
		queue_cmd(OP_DEL_KEY, 32'sd12345, 6'd0);
		queue_cmd(OP_SPARE, KEY_MAX, 6'h3f);
		queue_cmd(OP_DEL_SLOT, 32'sd0, 6'h3f);
		queue_cmd(OP_DEL_SLOT, 32'sd0, 6'd2);
		queue_cmd(OP_DEL_KEY, KEY_MIN, 6'd0);
		// limit below current count, then drain to empty
		queue_limit(7'd0);
		queue_cmd(OP_INSERT, 32'sd1, 6'd0);
		queue_cmd(OP_DEL_SLOT, 32'sd0, 6'd0);
		queue_cmd(OP_DEL_SLOT, 32'sd0, 6'd0);
		queue_cmd(OP_DEL_KEY, 32'sd0, 6'd0);
		queue_cmd(OP_DEL_SLOT, 32'sd0, 6'd0);
		queue_cmd(OP_SPARE, 32'sd0, 6'd0);
		queue_cmd(OP_INSERT, 32'sd5, 6'd0);
		// duplicates and ties
		queue_limit(7'd64);
		queue_cmd(OP_INSERT, 32'sd9, 6'd0);
		queue_cmd(OP_INSERT, 32'sd5, 6'd0);
		queue_cmd(OP_INSERT, 32'sd5, 6'd0);
		queue_cmd(OP_INSERT, 32'sd5, 6'd0);
		queue_cmd(OP_INSERT, 32'sd3, 6'd0);
		queue_cmd(OP_DEL_SLOT, 32'sd0, 6'd0);
		queue_cmd(OP_DEL_KEY, 32'sd5, 6'd0);
		queue_cmd(OP_DEL_SLOT, 32'sd0, 6'd1);

		// random phases: fill towards full, then mostly removals
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0:       lim = 7'd64;
				1:       lim = 7'd127;
				2:       lim = LIMIT_W'($urandom_range(1, 63));
				4:       lim = 7'd2;
				default: lim = 7'd64;
			endcase
			queue_limit(lim);
			for (int k = 0; k < 16; k++)
				key_pool[k] = key_t'($urandom);
			key_pool[0] = KEY_MIN;
			key_pool[1] = KEY_MAX;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				stim_calm = (ph == 5 && n >= 75);
				ins_pct   = (n < 110) ? 80 : 25;
				roll      = $urandom_range(0, 99);
				if (roll < 2)
					op = OP_SPARE;
				else if (roll < ins_pct)
					op = OP_INSERT;
				else if ($urandom_range(0, 1) == 0)
					op = OP_DEL_KEY;
				else
					op = OP_DEL_SLOT;
				key  = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 15)]
				                                  : key_t'($urandom);
				slot = ($urandom_range(0, 4) < 3) ? SLOT_W'($urandom_range(0, 15))
				                                  : SLOT_W'($urandom);
				queue_cmd(op, key, slot);
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_q.size() != 0 || cmd_valid || expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("min_heap_priority_queue_core regression: pass");
		else
			$display("min_heap_priority_queue_core regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
